// ----- rtl/core/hpack_huffman_encoder_assert.svh -----
// Assertion macros for the HPACK Huffman encoder.
`ifndef HPACK_HUFFMAN_ENCODER_ASSERT_SVH
`define HPACK_HUFFMAN_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while the active-low reset is asserted.
`define HPACK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define HPACK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPACK_ASSERT(label, clk, rstn, prop, msg)
`define HPACK_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/core/hpack_pkg.sv -----
// Shared types, constants and the Huffman code tables of the HPACK encoder.
`default_nettype none

package hpack_pkg;

    localparam int BYTE_W          = 8;
    localparam int SYM_W           = 8;
    localparam int CODE_W          = 30;
    localparam int LEN_W           = 5;
    localparam int ACC_W           = CODE_W + BYTE_W - 1;  // longest code + 7 leftover bits
    localparam int TOT_W           = 6;                    // holds 0..ACC_W
    localparam int OUT_CNT_W       = 24;
    localparam int COUNT_WIDTH_DEF = 24;

    localparam logic REQ_SYMBOL = 1'b0;
    localparam logic REQ_EOS    = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } hpack_state_t;

    // Control from the sequencer to the byte unit.
    typedef struct packed {
        logic step;  // a byte is taken this cycle
        logic clr;   // string ends, count restarts
    } hpack_ctl_t;

    localparam logic [CODE_W-1:0] CODE_ROM [256] = '{
        30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
        30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
        30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
        30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
        30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
        30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
        30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
        30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
        30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
        30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
        30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
        30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
        30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
        30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
        30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
        30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
        30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
        30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
        30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
        30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
        30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
        30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9,
        30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc,
        30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
        30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0,
        30'hffffee, 30'h7fffe1, 30'h7fffe2, 30'h7fffe3,
        30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
        30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef,
        30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb,
        30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
        30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0,
        30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec,
        30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
        30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
        30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4,
        30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
        30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1,
        30'h3fffe7, 30'h7ffff2, 30'h3fffe8, 30'h1ffffec,
        30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
        30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed,
        30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0,
        30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
        30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9,
        30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
        30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
        30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3,
        30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef,
        30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
        30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
        30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea,
        30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
        30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
    };

    localparam logic [LEN_W-1:0] LEN_ROM [256] = '{
        5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
        5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
        5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
        5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
        5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
        5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
        5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
        5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
        5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
        5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
        5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
        5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
        5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
        5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
        5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
        5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
        5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
        5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
        5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
        5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
        5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
        5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
        5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
        5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
        5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
        5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
        5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
        5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
    };

endpackage

`default_nettype wire

// ----- rtl/core/hpack_byte_unit.sv -----
// Shared byte extractor (barrel shift) and saturating per-string byte counter.
`default_nettype none

module hpack_byte_unit #(
    parameter int COUNT_WIDTH = hpack_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire hpack_pkg::hpack_ctl_t          ctl,
    input  wire logic [hpack_pkg::ACC_W-1:0]    acc,
    input  wire logic [hpack_pkg::TOT_W-1:0]    total,
    output logic      [hpack_pkg::BYTE_W-1:0]   byte_o,
    output logic      [hpack_pkg::OUT_CNT_W-1:0] count_o
);

    logic [hpack_pkg::TOT_W-1:0] shamt;
    logic [COUNT_WIDTH-1:0]      cnt_reg;
    logic [COUNT_WIDTH-1:0]      cnt_next;
    logic [COUNT_WIDTH-1:0]      cnt_inc;

    // top byte of the valid bits: acc[total-1 -: 8]
    assign shamt  = total - hpack_pkg::TOT_W'(hpack_pkg::BYTE_W);
    assign byte_o = hpack_pkg::BYTE_W'(acc >> shamt);

    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign count_o = hpack_pkg::OUT_CNT_W'(cnt_inc);

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.clr) begin
            cnt_next = '0;
        end else if (ctl.step) begin
            cnt_next = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/hpack_huffman_encoder.sv -----
// HPACK Huffman encoder top level: code lookup, bit accumulator, byte sequencer.
// Sequence: the accept cycle, then one byte per cycle while m_ready or an empty
// output slot lets it go; a byte shows on m_* in the cycle after its emit cycle. An
// item that makes no byte ends with its accept cycle. An item gives 0..4 bytes from
// the shared shift unit; s_ready stays low until its last byte is emitted.
// Reset (aresetn low, synchronous): accumulator empty, byte count zero, no output valid.
`default_nettype none

module hpack_huffman_encoder #(
    parameter int COUNT_WIDTH = hpack_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_req_type,
    input  wire logic [hpack_pkg::SYM_W-1:0]     s_symbol,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [hpack_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                                 m_last,
    output logic      [hpack_pkg::OUT_CNT_W-1:0] m_bytes_so_far
);

`include "hpack_huffman_encoder_assert.svh"

    localparam logic [hpack_pkg::TOT_W-1:0] ONE_BYTE = hpack_pkg::TOT_W'(hpack_pkg::BYTE_W);
    localparam logic [hpack_pkg::TOT_W-1:0] TWO_BYTES =
        hpack_pkg::TOT_W'(2 * hpack_pkg::BYTE_W);

    // Sequencer state. acc_reg holds the undrained code bits right aligned;
    // total_reg counts them. In idle total_reg < 8 and its bits are the partial byte.
    hpack_pkg::hpack_state_t          state_reg, state_next;
    logic [hpack_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [hpack_pkg::TOT_W-1:0]      total_reg, total_next;
    logic                             eos_reg, eos_next;

    // Output register
    logic                             m_valid_reg, m_valid_next;
    logic [hpack_pkg::BYTE_W-1:0]     m_byte_reg, m_byte_next;
    logic                             m_last_reg, m_last_next;
    logic [hpack_pkg::OUT_CNT_W-1:0]  m_cnt_reg, m_cnt_next;

    hpack_pkg::hpack_ctl_t            ctl;
    logic [hpack_pkg::BYTE_W-1:0]     unit_byte;
    logic [hpack_pkg::OUT_CNT_W-1:0]  unit_count;

    logic                             in_xfer;
    logic                             out_free;
    logic [hpack_pkg::CODE_W-1:0]     code_val;
    logic [hpack_pkg::LEN_W-1:0]      code_len;
    logic [2:0]                       used_bits;
    logic [3:0]                       pad_shamt;
    logic [2*hpack_pkg::BYTE_W-1:0]   pad_word;
    logic [hpack_pkg::TOT_W-1:0]      total_sym;
    logic [hpack_pkg::TOT_W-1:0]      total_left;

    assign s_ready  = (state_reg == hpack_pkg::ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // code ROM lookup
    assign code_val = hpack_pkg::CODE_ROM[s_symbol];
    assign code_len = hpack_pkg::LEN_ROM[s_symbol];

    // End of string: partial byte moved to the MSBs, rest filled with ones (EOS prefix).
    assign used_bits = total_reg[2:0];
    assign pad_shamt = 4'(hpack_pkg::BYTE_W) - {1'b0, used_bits};
    assign pad_word  = {acc_reg[hpack_pkg::BYTE_W-1:0], {hpack_pkg::BYTE_W{1'b1}}} << pad_shamt;

    assign total_sym  = total_reg + hpack_pkg::TOT_W'(code_len);
    assign total_left = total_reg - ONE_BYTE;

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        total_next   = total_reg;
        eos_next     = eos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_cnt_next   = m_cnt_reg;
        ctl          = '0;

        case (state_reg)
            hpack_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_req_type == hpack_pkg::REQ_EOS) begin
                        eos_next = 1'b1;
                        acc_next = hpack_pkg::ACC_W'(pad_word[2*hpack_pkg::BYTE_W-1:
                                                              hpack_pkg::BYTE_W]);
                        if (used_bits != 3'd0) begin
                            total_next = ONE_BYTE;
                            state_next = hpack_pkg::ST_EMIT;
                        end else begin
                            // empty accumulator: nothing to flush, count restarts
                            total_next = '0;
                            ctl.clr    = 1'b1;
                        end
                    end else begin
                        eos_next   = 1'b0;
                        acc_next   = (acc_reg << code_len) | hpack_pkg::ACC_W'(code_val);
                        total_next = total_sym;
                        if (total_sym >= ONE_BYTE) begin
                            state_next = hpack_pkg::ST_EMIT;
                        end
                    end
                end
            end
            hpack_pkg::ST_EMIT: begin
                // one byte per cycle through the shared shifter when the output slot frees
                if (out_free) begin
                    ctl.step     = 1'b1;
                    m_valid_next = 1'b1;
                    m_byte_next  = unit_byte;
                    m_cnt_next   = unit_count;
                    m_last_next  = (total_reg < TWO_BYTES);
                    total_next   = total_left;
                    if (total_reg < TWO_BYTES) begin
                        state_next = hpack_pkg::ST_IDLE;
                        if (eos_reg) begin
                            ctl.clr    = 1'b1;
                            total_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = hpack_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hpack_pkg::ST_IDLE;
            total_reg   <= '0;
            eos_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            eos_reg     <= eos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_cnt_reg  <= m_cnt_next;
    end

    hpack_byte_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_byte_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .acc     (acc_reg),
        .total   (total_reg),
        .byte_o  (unit_byte),
        .count_o (unit_count)
    );

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_last         = m_last_reg;
    assign m_bytes_so_far = m_cnt_reg;

    // Idle means only a partial byte is left.
    `HPACK_ASSERT(a_idle_partial, aclk, aresetn, (state_reg == hpack_pkg::ST_IDLE) |-> (total_reg < ONE_BYTE), "idle with a full byte pending")
    // The emit state always has a byte to take.
    `HPACK_ASSERT(a_emit_has_byte, aclk, aresetn, (state_reg == hpack_pkg::ST_EMIT) |-> (total_reg >= ONE_BYTE), "emit state without a full byte")
    // Every delivered byte is counted.
    `HPACK_ASSERT(a_count_nonzero, aclk, aresetn, m_valid |-> (m_bytes_so_far != '0), "result byte with zero count")
    // The last byte of an item returns the sequencer to idle.
    `HPACK_ASSERT(a_last_to_idle, aclk, aresetn, (ctl.step && m_last_next) |=> (state_reg == hpack_pkg::ST_IDLE), "last byte did not end the item")
    // Out of reset nothing is offered.
    `HPACK_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "output valid right after reset")

endmodule

`default_nettype wire

// ----- verif/hpack_huffman_encoder_tb.sv -----
// Self-checking testbench for the HPACK Huffman string encoder.
`timescale 1ns / 100ps

module hpack_huffman_encoder_tb;

    // Package constants used here
    localparam int   BYTE_W     = hpack_pkg::BYTE_W;
    localparam int   SYM_W      = hpack_pkg::SYM_W;
    localparam int   OUT_CNT_W  = hpack_pkg::OUT_CNT_W;
    localparam logic REQ_SYMBOL = hpack_pkg::REQ_SYMBOL;
    localparam logic REQ_EOS    = hpack_pkg::REQ_EOS;

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    localparam int CNT_W         = 24;     // matches the default COUNT_WIDTH
    localparam int ITEMS_PER_PH  = 100;    // random items per idling phase
    localparam int STALL_LIMIT   = 1000;   // cycles with no transfer at all
    localparam int TAIL_CYCLES   = 8;      // extra cycles once the queue drains

    // Independent copy of the RFC 7541 Appendix B code table.
    localparam int CODE_TAB [256] = '{
        'h1ff8, 'h7fffd8, 'hfffffe2, 'hfffffe3, 'hfffffe4, 'hfffffe5, 'hfffffe6, 'hfffffe7,
        'hfffffe8, 'hffffea, 'h3ffffffc, 'hfffffe9, 'hfffffea, 'h3ffffffd, 'hfffffeb,
        'hfffffec,
        'hfffffed, 'hfffffee, 'hfffffef, 'hffffff0, 'hffffff1, 'hffffff2, 'h3ffffffe,
        'hffffff3,
        'hffffff4, 'hffffff5, 'hffffff6, 'hffffff7, 'hffffff8, 'hffffff9, 'hffffffa,
        'hffffffb,
        'h14, 'h3f8, 'h3f9, 'hffa, 'h1ff9, 'h15, 'hf8, 'h7fa,
        'h3fa, 'h3fb, 'hf9, 'h7fb, 'hfa, 'h16, 'h17, 'h18,
        'h0, 'h1, 'h2, 'h19, 'h1a, 'h1b, 'h1c, 'h1d,
        'h1e, 'h1f, 'h5c, 'hfb, 'h7ffc, 'h20, 'hffb, 'h3fc,
        'h1ffa, 'h21, 'h5d, 'h5e, 'h5f, 'h60, 'h61, 'h62,
        'h63, 'h64, 'h65, 'h66, 'h67, 'h68, 'h69, 'h6a,
        'h6b, 'h6c, 'h6d, 'h6e, 'h6f, 'h70, 'h71, 'h72,
        'hfc, 'h73, 'hfd, 'h1ffb, 'h7fff0, 'h1ffc, 'h3ffc, 'h22,
        'h7ffd, 'h3, 'h23, 'h4, 'h24, 'h5, 'h25, 'h26,
        'h27, 'h6, 'h74, 'h75, 'h28, 'h29, 'h2a, 'h7,
        'h2b, 'h76, 'h2c, 'h8, 'h9, 'h2d, 'h77, 'h78,
        'h79, 'h7a, 'h7b, 'h7ffe, 'h7fc, 'h3ffd, 'h1ffd, 'hffffffc,
        'hfffe6, 'h3fffd2, 'hfffe7, 'hfffe8, 'h3fffd3, 'h3fffd4, 'h3fffd5, 'h7fffd9,
        'h3fffd6, 'h7fffda, 'h7fffdb, 'h7fffdc, 'h7fffdd, 'h7fffde, 'hffffeb, 'h7fffdf,
        'hffffec, 'hffffed, 'h3fffd7, 'h7fffe0, 'hffffee, 'h7fffe1, 'h7fffe2, 'h7fffe3,
        'h7fffe4, 'h1fffdc, 'h3fffd8, 'h7fffe5, 'h3fffd9, 'h7fffe6, 'h7fffe7, 'hffffef,
        'h3fffda, 'h1fffdd, 'hfffe9, 'h3fffdb, 'h3fffdc, 'h7fffe8, 'h7fffe9, 'h1fffde,
        'h7fffea, 'h3fffdd, 'h3fffde, 'hfffff0, 'h1fffdf, 'h3fffdf, 'h7fffeb, 'h7fffec,
        'h1fffe0, 'h1fffe1, 'h3fffe0, 'h1fffe2, 'h7fffed, 'h3fffe1, 'h7fffee, 'h7fffef,
        'hfffea, 'h3fffe2, 'h3fffe3, 'h3fffe4, 'h7ffff0, 'h3fffe5, 'h3fffe6, 'h7ffff1,
        'h3ffffe0, 'h3ffffe1, 'hfffeb, 'h7fff1, 'h3fffe7, 'h7ffff2, 'h3fffe8, 'h1ffffec,
        'h3ffffe2, 'h3ffffe3, 'h3ffffe4, 'h7ffffde, 'h7ffffdf, 'h3ffffe5, 'hfffff1,
        'h1ffffed,
        'h7fff2, 'h1fffe3, 'h3ffffe6, 'h7ffffe0, 'h7ffffe1, 'h3ffffe7, 'h7ffffe2, 'hfffff2,
        'h1fffe4, 'h1fffe5, 'h3ffffe8, 'h3ffffe9, 'hffffffd, 'h7ffffe3, 'h7ffffe4,
        'h7ffffe5,
        'hfffec, 'hfffff3, 'hfffed, 'h1fffe6, 'h3fffe9, 'h1fffe7, 'h1fffe8, 'h7ffff3,
        'h3fffea, 'h3fffeb, 'h1ffffee, 'h1ffffef, 'hfffff4, 'hfffff5, 'h3ffffea, 'h7ffff4,
        'h3ffffeb, 'h7ffffe6, 'h3ffffec, 'h3ffffed, 'h7ffffe7, 'h7ffffe8, 'h7ffffe9,
        'h7ffffea,
        'h7ffffeb, 'hffffffe, 'h7ffffec, 'h7ffffed, 'h7ffffee, 'h7ffffef, 'h7fffff0,
        'h3ffffee
    };

    localparam int LEN_TAB [256] = '{
        13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
        28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
        6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
        5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
        13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
        7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
        15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
        6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
        20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
        24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
        22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
        21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
        26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
        19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
        20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
        26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
    };

    // One encoded byte as it should appear on the result channel.
    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        logic                 last;
        logic [OUT_CNT_W-1:0] bytes_so_far;
    } enc_byte_t;

    // Directed row: typed rows carry at most one byte, and it is always the last one.
    localparam bit TYPED = 1'b1;
    localparam bit PRED  = 1'b0;

    typedef struct packed {
        logic                 req;
        logic [SYM_W-1:0]     sym;
        logic                 typed;
        logic [2:0]           n_bytes;
        logic [BYTE_W-1:0]    out_byte;
        logic [OUT_CNT_W-1:0] bytes_so_far;
    } dir_row_t;

    localparam int N_DIRECTED = 25;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{REQ_EOS,    8'h00, TYPED, 3'd0, 8'h00, 24'd0},  // flush right after reset: nothing
        '{REQ_SYMBOL, 8'h30, TYPED, 3'd0, 8'h00, 24'd0},  // 5-bit code, no byte yet
        '{REQ_EOS,    8'h00, TYPED, 3'd1, 8'h07, 24'd1},  // partial byte padded with ones
        '{REQ_SYMBOL, 8'h26, TYPED, 3'd1, 8'hf8, 24'd1},  // 8-bit code lands on a boundary
        '{REQ_EOS,    8'hff, TYPED, 3'd0, 8'h00, 24'd0},  // empty flush, symbol ignored
        '{REQ_SYMBOL, 8'h26, TYPED, 3'd1, 8'hf8, 24'd1},  // count restarted by the flush
        '{REQ_SYMBOL, 8'h00, PRED,  3'd0, 8'h00, 24'd0},  // lowest symbol, 13 bits
        '{REQ_SYMBOL, 8'hff, PRED,  3'd0, 8'h00, 24'd0},  // highest symbol, 26 bits
        '{REQ_SYMBOL, 8'h0a, PRED,  3'd0, 8'h00, 24'd0},  // 30-bit codes
        '{REQ_SYMBOL, 8'h0d, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h80, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_EOS,    8'h5a, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h30, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h0a, PRED,  3'd0, 8'h00, 24'd0},  // 5 + 30 bits: four bytes
        '{REQ_SYMBOL, 8'h16, PRED,  3'd0, 8'h00, 24'd0},  // 3 + 30 bits: four bytes
        '{REQ_EOS,    8'h00, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h61, PRED,  3'd0, 8'h00, 24'd0},  // eight 5-bit codes = 5 bytes
        '{REQ_SYMBOL, 8'h61, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h61, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h61, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h61, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h61, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h61, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_SYMBOL, 8'h61, PRED,  3'd0, 8'h00, 24'd0},
        '{REQ_EOS,    8'h00, PRED,  3'd0, 8'h00, 24'd0}   // accumulator empty again
    };

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = REQ_SYMBOL;
    logic [SYM_W-1:0]     s_symbol = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 m_last;
    logic [OUT_CNT_W-1:0] m_bytes_so_far;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    hpack_huffman_encoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last         (m_last),
        .m_bytes_so_far (m_bytes_so_far)
    );

    // ------------------------------------------------------------------
    // Encoder model: bit accumulator plus per-string byte count
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] acc_byte = '0;   // used bits MSB aligned
    int                acc_free = 8;    // free bit positions, 1..8
    longint unsigned   str_count = 0;   // bytes emitted in this string
    enc_byte_t         bytes_due [$];   // encoded bytes still to arrive
    int                errors = 0;
    int                src_idle_pct = 0;
    int                snk_idle_pct = 0;

    function automatic logic [OUT_CNT_W-1:0] bump_count();
        if (str_count < ((64'd1 << CNT_W) - 1))
            str_count++;
        return str_count[OUT_CNT_W-1:0];
    endfunction

    // Advance the model by one accepted item; queue its bytes when keep is set.
    task automatic encode_item(input logic req, input logic [SYM_W-1:0] sym, input bit keep);
        enc_byte_t       outs [4];
        int              n;
        int              len;
        int              total;
        longint unsigned acc;
        n = 0;
        if (req == REQ_EOS) begin
            // pad the partial byte with EOS ones, then start a fresh string
            if (acc_free < 8) begin
                outs[0] = '{acc_byte | 8'((1 << acc_free) - 1), 1'b0, bump_count()};
                n = 1;
            end
            acc_byte  = '0;
            acc_free  = 8;
            str_count = 0;
        end else begin
            len   = LEN_TAB[sym];
            total = (8 - acc_free) + len;
            acc   = (longint'(acc_byte >> acc_free) << len) | longint'(CODE_TAB[sym]);
            while (total >= 8) begin
                outs[n] = '{8'(acc >> (total - 8)), 1'b0, bump_count()};
                n++;
                total -= 8;
            end
            if (total == 0) begin
                acc_byte = '0;
                acc_free = 8;
            end else begin
                acc_byte = 8'((acc & ((64'd1 << total) - 1)) << (8 - total));
                acc_free = 8 - total;
            end
        end
        if (n > 0)
            outs[n-1].last = 1'b1;
        if (keep)
            for (int i = 0; i < n; i++)
                bytes_due.insert(bytes_due.size(), outs[i]);
    endtask

    // ------------------------------------------------------------------
    // Input side: hold valid until the transfer, then update the model
    // ------------------------------------------------------------------
    task automatic send_item(input logic req, input logic [SYM_W-1:0] sym, input bit keep);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_symbol   <= sym;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        encode_item(req, sym, keep);
    endtask

    // Mostly printable text, some arbitrary octets, some long-code octets.
    function automatic logic [SYM_W-1:0] pick_symbol();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 8'($urandom_range(126, 32));
        else if (roll < 85)
            return 8'($urandom_range(255));
        else if (roll < 92)
            return 8'($urandom_range(31));
        return 8'($urandom_range(255, 128));
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order compare
    // ------------------------------------------------------------------
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge aclk) begin
        enc_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bytes_due.size() == 0) begin
                $error("unexpected byte %h on the result channel", m_out_byte);
                errors++;
            end else begin
                want = bytes_due.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_out_byte);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    errors++;
                end
                if (m_bytes_so_far !== want.bytes_so_far) begin
                    $error("bytes_so_far: expected %0d, got %0d",
                           want.bytes_so_far, m_bytes_so_far);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** hpack_huffman_encoder: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        dir_row_t row;
        int       sent;
        int       str_len;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase 0: sender idles 34%, receiver 50%; the directed table runs here too.
        src_idle_pct = 34;
        snk_idle_pct = 50;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            send_item(row.req, row.sym, !row.typed);
            if (row.typed && row.n_bytes != 0)
                bytes_due.insert(bytes_due.size(),
                                 enc_byte_t'{row.out_byte, 1'b1, row.bytes_so_far});
        end

        // Random strings; phase 1 swaps the idle rates, phase 2 runs flat out.
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 50 : 0;
            snk_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 34 : 0;
            sent = 0;
            while (sent < ITEMS_PER_PH) begin
                if ($urandom_range(99) < 90) begin
                    // well-formed string: octets, then end of string
                    str_len = $urandom_range(10, 1);
                    for (int k = 0; k < str_len; k++)
                        send_item(REQ_SYMBOL, pick_symbol(), 1'b1);
                    send_item(REQ_EOS, 8'($urandom_range(255)), 1'b1);
                    sent += str_len + 1;
                end else begin
                    // noise: stray flush or a lone octet that carries into the next string
                    if ($urandom_range(1) == 0)
                        send_item(REQ_EOS, 8'($urandom_range(255)), 1'b1);
                    else
                        send_item(REQ_SYMBOL, 8'($urandom_range(255)), 1'b1);
                    sent++;
                end
            end
        end
        s_valid <= 1'b0;

        // Drain, then give a late extra byte the chance to show up.
        while (bytes_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("** hpack_huffman_encoder: PASSED **");
        else
            $display("** hpack_huffman_encoder: FAILED **");
        $finish;
    end

endmodule
